// ===== rtl/core/psh_pkg.sv =====
`default_nettype none

package psh_pkg;

    localparam int VALUE_W = 32;
    localparam int KEY_W   = 33;
    localparam int IDX_W   = 10;
    localparam int STAT_W  = 2;

    localparam logic [IDX_W-1:0] IDX_SAT = 10'h3FF;

    typedef enum logic [STAT_W-1:0] {
        PSH_STORED  = 2'd0,
        PSH_MATCH   = 2'd1,
        PSH_IGNORED = 2'd2,
        PSH_FULL    = 2'd3
    } psh_status_t;

    // Lookup request handed from the front end to the chain engine.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               key_in_range;
    } psh_lookup_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } psh_lookup_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/psh_if.sv =====
`default_nettype none

interface psh_item_if;
    import psh_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      first;

    modport source (output valid, value, first, input ready);
    modport sink   (input valid, value, first, output ready);
endinterface

interface psh_result_if;
    import psh_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  current_index;
    logic [IDX_W-1:0]  partner_index;

    modport source (output valid, status, current_index, partner_index, input ready);
    modport sink   (input valid, status, current_index, partner_index, output ready);
endinterface

interface psh_cfg_if;
    import psh_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/psh_bucket_unit.sv =====
`default_nettype none

module psh_bucket_unit #(
    parameter int BUCKET_COUNT = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [psh_pkg::KEY_W-1:0]             operand,
    output logic      [$clog2(BUCKET_COUNT)-1:0]       bucket,
    output logic                                       done
);
    import psh_pkg::*;

    localparam int BW      = $clog2(BUCKET_COUNT);
    localparam bit IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic [BW-1:0] result_reg;
            logic          done_reg;

            // Low bits of the two's complement word are already the
            // nonnegative remainder.
            always_ff @(posedge clk) begin
                if (start)
                begin
                    result_reg <= operand[BW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            assign bucket = result_reg;
            assign done   = done_reg;
        end
        else begin : g_recip
            localparam int                RW      = BW + 1;
            localparam logic [RW-1:0]     N_W     = RW'(BUCKET_COUNT);
            localparam longint unsigned   RECIP_L = (64'd1 << KEY_W) / 64'(BUCKET_COUNT);
            localparam logic [31:0]       RECIP   = 32'(RECIP_L);

            logic [KEY_W-1:0] mag_reg;
            logic             neg_reg;
            logic [48:0]      prod_lo_reg;
            logic [48:0]      prod_hi_reg;
            logic [RW-1:0]    quot_reg;
            logic [RW-1:0]    rem_reg;
            logic [BW-1:0]    result_reg;
            logic [3:0]       stage_reg;
            logic             done_reg;
            logic [KEY_W-1:0] abs_val;
            logic [64:0]      prod_sum;
            logic [RW-1:0]    rem_est;
            logic [RW-1:0]    rem_fix;
            logic [RW-1:0]    rem_pos;

            assign abs_val  = operand[KEY_W-1] ? (~operand + KEY_W'(1)) : operand;
            assign prod_sum = {prod_hi_reg, 16'd0} + {16'd0, prod_lo_reg};
            // Quotient estimate is at most one short, so the remainder is
            // below twice the bucket count and fits in RW bits.
            assign rem_est  = mag_reg[RW-1:0] - RW'(quot_reg * N_W);
            assign rem_fix  = (rem_reg >= N_W) ? (rem_reg - N_W) : rem_reg;
            // Fold a negative remainder back into range.
            assign rem_pos  = (neg_reg && (rem_fix != '0)) ? (N_W - rem_fix) : rem_fix;

            // Reciprocal multiply in two 16-bit halves, then one correction.
            always_ff @(posedge clk) begin
                if (start)
                begin
                    mag_reg <= abs_val;
                    neg_reg <= operand[KEY_W-1];
                end
                if (stage_reg[0])
                begin
                    prod_lo_reg <= 49'(mag_reg) * 49'(RECIP[15:0]);
                    prod_hi_reg <= 49'(mag_reg) * 49'(RECIP[31:16]);
                end
                if (stage_reg[1])
                begin
                    quot_reg <= prod_sum[KEY_W +: RW];
                end
                if (stage_reg[2])
                begin
                    rem_reg <= rem_est;
                end
                if (stage_reg[3])
                begin
                    result_reg <= rem_pos[BW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n)
                begin
                    stage_reg <= '0;
                    done_reg  <= 1'b0;
                end
                else
                begin
                    stage_reg <= {stage_reg[2:0], start};
                    done_reg  <= stage_reg[3];
                end
            end

            assign bucket = result_reg;
            assign done   = done_reg;
        end
    endgenerate

endmodule

`default_nettype wire

// ===== rtl/core/psh_chain_engine.sv =====
`default_nettype none

module psh_chain_engine #(
    parameter int BUCKET_COUNT = 1024,
    parameter int MAX_ITEMS    = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire psh_pkg::psh_lookup_req_t          req,
    input  wire logic [$clog2(MAX_ITEMS+1)-1:0]    count,
    output psh_pkg::psh_lookup_rsp_t               rsp,
    output logic      [$clog2(MAX_ITEMS)-1:0]      partner
);
    import psh_pkg::*;

    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = $clog2(MAX_ITEMS);
    localparam int WW = VALUE_W + CW + BW;

    typedef enum logic [4:0] {
        E_IDLE  = 5'b00001,
        E_CALC  = 5'b00010,
        E_HEAD  = 5'b00100,
        E_WALK  = 5'b01000,
        E_WRITE = 5'b10000
    } eng_state_t;

    // Head entries and slot words carry no reset: a head is trusted only if
    // it points below the fill count at a slot tagged with the same bucket.
    logic [CW-1:0] head_mem [BUCKET_COUNT];
    logic [WW-1:0] slot_mem [MAX_ITEMS];

    eng_state_t      state_reg, state_next;
    psh_lookup_req_t req_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   head_a_reg, head_b_reg;
    logic [WW-1:0]   slot_rd_reg;
    logic            done_reg, done_next;
    logic            hit_reg, hit_next;
    logic [SW-1:0]   partner_reg;

    logic [BW-1:0]   bk, bv;
    logic            done_k, done_v;
    logic            head_rd;
    logic            head_wr;
    logic            slot_rd_en;
    logic [SW-1:0]   slot_rd_addr;

    logic [VALUE_W-1:0] slot_key;
    logic [CW-1:0]      slot_link;
    logic [BW-1:0]      slot_tag;
    logic               tag_ok;

    psh_bucket_unit #(.BUCKET_COUNT(BUCKET_COUNT)) u_key_bucket (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand (req.key),
        .bucket  (bk),
        .done    (done_k)
    );

    psh_bucket_unit #(.BUCKET_COUNT(BUCKET_COUNT)) u_val_bucket (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand ({req.value[VALUE_W-1], req.value}),
        .bucket  (bv),
        .done    (done_v)
    );

    assign slot_key  = slot_rd_reg[WW-1 -: VALUE_W];
    assign slot_link = slot_rd_reg[CW+BW-1 -: CW];
    assign slot_tag  = slot_rd_reg[BW-1:0];
    assign tag_ok    = (slot_tag == bk);

    assign head_rd = (state_reg == E_CALC) && done_k && done_v;
    assign head_wr = (state_reg == E_WRITE);

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        slot_rd_en   = 1'b0;
        slot_rd_addr = cur_reg[SW-1:0];
        done_next    = 1'b0;
        hit_next     = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    state_next = E_CALC;
                end
            end
            E_CALC:
            begin
                if (done_k && done_v)
                begin
                    state_next = E_HEAD;
                end
            end
            E_HEAD:
            begin
                if (req_reg.key_in_range && (head_a_reg < count_reg))
                begin
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = head_a_reg[SW-1:0];
                    cur_next     = head_a_reg;
                    state_next   = E_WALK;
                end
                else
                begin
                    state_next = E_WRITE;
                end
            end
            E_WALK:
            begin
                if (tag_ok && (slot_key == req_reg.key[VALUE_W-1:0]))
                begin
                    done_next  = 1'b1;
                    hit_next   = 1'b1;
                    state_next = E_IDLE;
                end
                else if (tag_ok && (slot_link < cur_reg))
                begin
                    // Follow the chain toward older slots.
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = slot_link[SW-1:0];
                    cur_next     = slot_link;
                end
                else
                begin
                    state_next = E_WRITE;
                end
            end
            E_WRITE:
            begin
                done_next  = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (head_rd)
        begin
            head_a_reg <= head_mem[bk];
            head_b_reg <= head_mem[bv];
        end
        if (head_wr)
        begin
            head_mem[bv] <= count_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (slot_rd_en)
        begin
            slot_rd_reg <= slot_mem[slot_rd_addr];
        end
        if (head_wr)
        begin
            slot_mem[count_reg[SW-1:0]] <= {req_reg.value, head_b_reg, bv};
        end
    end

    always_ff @(posedge clk) begin
        if (start && (state_reg == E_IDLE))
        begin
            req_reg   <= req;
            count_reg <= count;
        end
        cur_reg <= cur_next;
        if (hit_next)
        begin
            partner_reg <= cur_reg[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hit  = hit_reg;
    assign partner  = partner_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pair_sum_hash_matcher.sv =====
`default_nettype none

// Pair-sum matcher: a stream of signed 32-bit words is searched for the first
// pair whose sum equals target_sum. A word with first set opens a new array.
// Every input word yields exactly one result word: status 0 (stored), 1
// (match, partner_index holds the newest earlier position with the needed
// value), 2 (ignored, a match was already found in this array) or 3 (table
// full, MAX_ITEMS positions used). Positions saturate at 1023 in the result.
// One word is handled at a time. Words after a match or with a full table
// finish straight from the accept. A lookup visits the chain entries in the
// complement's bucket, each visit being one read of the slot memory, and
// stores its word unless it ends on a match.
// With a power-of-two BUCKET_COUNT the bucket index is a mask, otherwise a
// pipelined reciprocal remainder unit computes it. A new array needs no
// clearing pass: bucket heads are checked against the fill count and a
// bucket tag kept with every slot. The user must write target_sum over the
// cfg channel only while no word is in flight; the block does not enforce it.
module pair_sum_hash_matcher #(
    parameter int BUCKET_COUNT = 1024,
    parameter int MAX_ITEMS    = 1024
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    psh_item_if.sink      item,
    psh_result_if.source  result,
    psh_cfg_if.sink       cfg
);
    import psh_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = $clog2(MAX_ITEMS);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_BUSY = 3'b010,
        T_FIN  = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [VALUE_W-1:0] target_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic               matched_reg, matched_next;
    logic [CW-1:0]      pos_reg;

    // Output register: holds one finished word until the sink takes it.
    logic               out_valid_reg;
    psh_status_t        out_status_reg;
    logic [IDX_W-1:0]   out_cur_reg;
    logic [IDX_W-1:0]   out_partner_reg;

    // Pending word while the output register is still occupied.
    psh_status_t        pend_status_reg;
    logic [IDX_W-1:0]   pend_cur_reg;
    logic [IDX_W-1:0]   pend_partner_reg;

    logic               accept;
    logic               out_free;
    logic [CW-1:0]      eff_count;
    logic               eff_matched;
    logic               eng_start;
    psh_lookup_req_t    eng_req;
    psh_lookup_rsp_t    eng_rsp;
    logic [SW-1:0]      eng_partner;
    logic [KEY_W-1:0]   key;

    logic               fin_valid;
    psh_status_t        fin_status;
    logic [CW-1:0]      fin_pos;
    logic [IDX_W-1:0]   fin_partner;
    logic [IDX_W-1:0]   fin_cur;
    logic [31:0]        pos_ext;
    logic [31:0]        partner_ext;
    logic               load_out;
    logic               load_pend;

    assign item.ready = (state_reg == T_IDLE);
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    // A first word restarts the array before it is handled.
    assign eff_count   = item.first ? '0 : count_reg;
    assign eff_matched = item.first ? 1'b0 : matched_reg;

    // Complement is formed one bit wider so it never wraps.
    assign key = {target_reg[VALUE_W-1], target_reg} - {item.value[VALUE_W-1], item.value};

    assign eng_req.key          = key;
    assign eng_req.value        = item.value;
    assign eng_req.key_in_range = (key[KEY_W-1] == key[KEY_W-2]);
    assign eng_start            = accept && !eff_matched && (eff_count < MAX_C);

    psh_chain_engine #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .MAX_ITEMS    (MAX_ITEMS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (eng_start),
        .req     (eng_req),
        .count   (eff_count),
        .rsp     (eng_rsp),
        .partner (eng_partner)
    );

    // Finished word for this cycle, either straight from the accept or from
    // the engine's response.
    always_comb begin
        fin_valid    = 1'b0;
        fin_status   = PSH_STORED;
        fin_pos      = pos_reg;
        partner_ext  = 32'd0;
        count_next   = count_reg;
        matched_next = matched_reg;
        if (accept)
        begin
            fin_pos = eff_count;
            if (eff_matched)
            begin
                fin_valid    = 1'b1;
                fin_status   = PSH_IGNORED;
                matched_next = 1'b1;
                count_next   = (eff_count < MAX_C) ? CW'(eff_count + CW'(1)) : eff_count;
            end
            else if (eff_count >= MAX_C)
            begin
                fin_valid    = 1'b1;
                fin_status   = PSH_FULL;
                matched_next = 1'b0;
                count_next   = eff_count;
            end
            else
            begin
                matched_next = 1'b0;
                count_next   = CW'(eff_count + CW'(1));
            end
        end
        else if ((state_reg == T_BUSY) && eng_rsp.done)
        begin
            fin_valid = 1'b1;
            if (eng_rsp.hit)
            begin
                fin_status   = PSH_MATCH;
                partner_ext  = 32'(eng_partner);
                matched_next = 1'b1;
            end
        end
    end

    assign pos_ext     = 32'(fin_pos);
    assign fin_cur     = (pos_ext > 32'(IDX_SAT)) ? IDX_SAT : pos_ext[IDX_W-1:0];
    assign fin_partner = partner_ext[IDX_W-1:0];

    assign load_out  = (fin_valid && out_free) || ((state_reg == T_FIN) && out_free);
    assign load_pend = fin_valid && !out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (eng_start)
                begin
                    state_next = T_BUSY;
                end
                else if (load_pend)
                begin
                    state_next = T_FIN;
                end
            end
            T_BUSY:
            begin
                if (eng_rsp.done)
                begin
                    state_next = out_free ? T_IDLE : T_FIN;
                end
            end
            T_FIN:
            begin
                if (out_free)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Payload: hold position, pending word and output fields.
    always_ff @(posedge clk) begin
        if (accept)
        begin
            pos_reg <= eff_count;
        end
        if (load_pend)
        begin
            pend_status_reg  <= fin_status;
            pend_cur_reg     <= fin_cur;
            pend_partner_reg <= fin_partner;
        end
        if (load_out)
        begin
            if (state_reg == T_FIN)
            begin
                out_status_reg  <= pend_status_reg;
                out_cur_reg     <= pend_cur_reg;
                out_partner_reg <= pend_partner_reg;
            end
            else
            begin
                out_status_reg  <= fin_status;
                out_cur_reg     <= fin_cur;
                out_partner_reg <= fin_partner;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            target_reg    <= '0;
            count_reg     <= '0;
            matched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            matched_reg <= matched_next;
            if (cfg.valid && cfg.ready)
            begin
                target_reg <= cfg.data;
            end
            // Advance the output register: fill on load, drop once taken.
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.current_index = out_cur_reg;
    assign result.partner_index = out_partner_reg;

endmodule

`default_nettype wire

// ===== dv/psh_pair_checker.sv =====
`timescale 1ns / 100ps

// Watches the item, result and target channels of the pair-sum matcher,
// predicts one result word per accepted item word and compares in order.
module psh_pair_checker
    import psh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    psh_item_if       item,
    psh_result_if     result,
    psh_cfg_if        cfg,
    output int        fail_count,
    output int        pending
);

    localparam int SLOTS       = 1024;
    localparam int BUCKETS     = 1024;
    localparam int NO_SLOT     = SLOTS;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        psh_status_t      status;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] partner;
    } verdict_t;

    logic [VALUE_W-1:0]        key_mem  [SLOTS];
    int                        link_mem [SLOTS];
    int                        head_mem [BUCKETS];
    int                        fill;
    bit                        found;
    logic signed [VALUE_W-1:0] target;
    verdict_t                  verdict_q [$];
    int                        reports;

    // Nonnegative mod of a two's complement key by a power-of-two count.
    function automatic int bucket_of(logic [VALUE_W-1:0] k);
        return int'(k[9:0]);
    endfunction

    function automatic void clear_table();
        foreach (head_mem[i])
            head_mem[i] = NO_SLOT;
        fill  = 0;
        found = 1'b0;
    endfunction

    function automatic int find_slot(logic [KEY_W-1:0] k);
        int slot;
        int steps;
        // a complement outside 32 bits can never equal a stored key
        if (k[KEY_W-1] != k[KEY_W-2])
            return NO_SLOT;
        slot  = head_mem[bucket_of(k[VALUE_W-1:0])];
        steps = 0;
        while (steps < SLOTS && slot < NO_SLOT)
        begin
            if (key_mem[slot] == k[VALUE_W-1:0])
                return slot;
            slot = link_mem[slot];
            steps++;
        end
        return NO_SLOT;
    endfunction

    function automatic verdict_t predict_word(logic [VALUE_W-1:0] v, logic f);
        verdict_t         r;
        logic [KEY_W-1:0] need;
        int               hit;
        int               b;
        if (f)
            clear_table();
        r.status  = PSH_STORED;
        r.cur     = (fill > int'(IDX_SAT)) ? IDX_SAT : fill[IDX_W-1:0];
        r.partner = '0;
        if (found)
        begin
            r.status = PSH_IGNORED;
            if (fill < SLOTS)
                fill++;
        end
        else if (fill >= SLOTS)
        begin
            r.status = PSH_FULL;
        end
        else
        begin
            need = {target[VALUE_W-1], target} - {v[VALUE_W-1], v};
            hit  = find_slot(need);
            if (hit < NO_SLOT)
            begin
                r.status  = PSH_MATCH;
                r.partner = hit[IDX_W-1:0];
                found     = 1'b1;
            end
            else
            begin
                b              = bucket_of(v);
                key_mem[fill]  = v;
                link_mem[fill] = head_mem[b];
                head_mem[b]    = fill;
            end
            fill++;
        end
        return r;
    endfunction

    task automatic report(string field, int want, int got);
        fail_count++;
        if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        reports++;
    endtask

    initial
    begin
        clear_table();
        target     = '0;
        fail_count = 0;
        pending    = 0;
        reports    = 0;
    end

    always @(posedge clk)
    begin : watch
        verdict_t want;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                target = cfg.data;
            if (item.valid && item.ready)
                verdict_q.push_back(predict_word(item.value, item.first));
            if (result.valid && result.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result word, expected none, actual status %0d",
                             $time, result.status);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (result.status != want.status)
                        report("status", want.status, result.status);
                    if (result.current_index != want.cur)
                        report("current_index", want.cur, result.current_index);
                    if (result.partner_index != want.partner)
                        report("partner_index", want.partner, result.partner_index);
                end
            end
        end
        pending = verdict_q.size();
    end

endmodule

// ===== dv/pair_sum_hash_matcher_tb.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the pair-sum matcher. The checker beside the
// block does all prediction; this module only drives words and judges.
module pair_sum_hash_matcher_tb;
    import psh_pkg::*;

    // Quiet cycles allowed: a full-chain walk plus the long receiver hold-off
    // (HOLD_CYCLES), taken several times over.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_WORDS    = 60;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_ONE_IN_FOUR
    } rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    psh_item_if   item_ch ();
    psh_result_if res_ch ();
    psh_cfg_if    cfg_ch ();

    int fail_count;
    int pending;
    int quiet_cycles = 0;

    // sender pacing and the hold-off request for the receiver
    bit gaps_on     = 1'b1;
    int burst_left  = 0;
    bit rx_hold_req = 1'b0;

    pair_sum_hash_matcher u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    psh_pair_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: end the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: switch between randomly chosen stall patterns, and hold off
    // entirely for a long stretch when asked.
    initial
    begin : rx_side
        rx_mode_t mode;
        int       span;
        int       tick;
        mode         = RX_ALWAYS;
        span         = 0;
        tick         = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            if (span == 0)
            begin
                mode = rx_mode_t'($urandom_range(RX_ALWAYS, RX_ONE_IN_FOUR));
                span = $urandom_range(20, 200);
            end
            span--;
            tick++;
            case (mode)
                RX_ALWAYS:      res_ch.ready <= 1'b1;
                RX_COIN:        res_ch.ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY:      res_ch.ready <= ($urandom_range(0, 9) != 0);
                default:        res_ch.ready <= (tick % 4 == 0);
            endcase
        end
    end

    // Offer one item word and hold it until accepted. Called at a falling
    // edge; returns at the falling edge after acceptance with valid still up.
    task automatic push_word(input logic [VALUE_W-1:0] v, input logic f);
        if (gaps_on && burst_left == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        item_ch.first <= f;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_target(input logic [VALUE_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One array of random words biased toward pairs that hit the target.
    // With run_on set the first mark is left off, so the words run on into
    // the previous array.
    task automatic run_array(input int len, input logic [VALUE_W-1:0] tgt, input bit run_on);
        logic [VALUE_W-1:0] seen [$];
        logic [VALUE_W-1:0] v;
        int                 pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 9);
            if (seen.size() == 0 && (pick <= 2 || pick == 6))
                pick = 3;
            case (pick)
                0, 1, 2: v = tgt - seen[$urandom_range(0, seen.size() - 1)];
                3, 4:    v = $urandom();
                5:
                begin
                    case ($urandom_range(0, 5))
                        0:       v = 32'h0000_0000;
                        1:       v = 32'hFFFF_FFFF;
                        2:       v = 32'h8000_0000;
                        3:       v = 32'h7FFF_FFFF;
                        4:       v = tgt;
                        default: v = ~tgt;
                    endcase
                end
                // same bucket as an earlier word, so chains grow
                6: v = seen[$urandom_range(0, seen.size() - 1)]
                       + (int'($urandom_range(0, 6)) - 3) * 1024;
                default: v = ($signed(tgt) >>> 1) + int'($urandom_range(0, 40)) - 20;
            endcase
            seen.push_back(v);
            push_word(v, (i == 0) && !run_on);
        end
    endtask

    initial
    begin : stimulus
        logic [VALUE_W-1:0] tgt;
        int                 sent;
        int                 len;

        item_ch.valid = 1'b0;
        item_ch.value = '0;
        item_ch.first = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset target of zero and no first mark: one array from reset.
        push_word(32'd5, 1'b0);
        push_word(-32'sd5, 1'b0);
        push_word(32'd7, 1'b0);
        drain();

        // Largest target: complements of the minimum and of -1 leave 32 bits.
        write_target(32'h7FFF_FFFF);
        push_word(32'h8000_0000, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word(32'h0000_0001, 1'b0);
        drain();

        // Smallest target: complement below the 32-bit range, then a hit.
        write_target(32'h8000_0000);
        push_word(32'h0000_0001, 1'b1);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        drain();

        // Shared bucket, negative key in it, hit deeper in the chain.
        write_target(32'd2048);
        push_word(32'd0, 1'b1);
        push_word(32'd1024, 1'b0);
        push_word(-32'sd1024, 1'b0);
        push_word(32'd1024, 1'b0);
        drain();

        // Repeated value: the newest copy must be reported.
        write_target(32'd10);
        push_word(32'd3, 1'b1);
        push_word(32'd3, 1'b0);
        push_word(32'd3, 1'b0);
        push_word(32'd7, 1'b0);
        drain();

        // Fill the table: even words never sum to an odd target, so every
        // slot gets used and the last words report a full table.
        write_target(32'd1);
        for (int i = 0; i < 1030; i++)
            push_word($urandom() & 32'hFFFF_FFFE, i == 0);
        drain();

        // Random phases, each under its own target.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       tgt = $urandom();
                1:       tgt = 32'h0000_0000;
                2:       tgt = 32'h7FFF_FFFF;
                3:       tgt = 32'h8000_0000;
                default: tgt = int'($urandom_range(0, 200)) - 100;
            endcase
            write_target(tgt);
            if (phase == 1)
                rx_hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                // keep offering while the receiver holds off
                gaps_on = (phase == 1 && sent < 40) ? 1'b0 : ($urandom_range(0, 3) != 0);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
                run_array(len, tgt, (sent > 0) && ($urandom_range(0, 9) == 0));
                sent += len;
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
